@@ design/rcws_pkg.sv @@
// Package with shared constants for the wall column setup.
package rcws_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAP_BITS_DEF  = 8;
  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;
  localparam logic [10:0] TEXTURE_WIDTH_RST = 11'd64;
  localparam logic [0:0] REG_SCREEN_HEIGHT = 1'b0;
  localparam logic [0:0] REG_TEXTURE_WIDTH = 1'b1;
  localparam int LINE_MAX = 32767;
  localparam int TEXEL_MAX = 1023;
endpackage

@@ design/rcws_if.sv @@
// Valid/ready channel interfaces for the input, result and configuration ports.
interface rcws_in_if #(parameter int FRAC_BITS = 16, parameter int MAP_BITS = 8);
  logic valid;
  logic ready;
  logic [MAP_BITS-1:0] cell_x;
  logic [MAP_BITS-1:0] cell_y;
  logic [MAP_BITS+FRAC_BITS-1:0] eye_x;
  logic [MAP_BITS+FRAC_BITS-1:0] eye_y;
  logic signed [FRAC_BITS+2:0] ray_x;
  logic signed [FRAC_BITS+2:0] ray_y;
  logic hit_side;
  logic step_x_negative;
  logic step_y_negative;
  modport source (output valid, cell_x, cell_y, eye_x, eye_y, ray_x, ray_y, hit_side,
                  step_x_negative, step_y_negative, input ready);
  modport sink (input valid, cell_x, cell_y, eye_x, eye_y, ray_x, ray_y, hit_side,
                step_x_negative, step_y_negative, output ready);
endinterface

interface rcws_out_if #(parameter int FRAC_BITS = 16, parameter int MAP_BITS = 8);
  logic valid;
  logic ready;
  logic [MAP_BITS+FRAC_BITS-1:0] wall_distance;
  logic [14:0] line_height;
  logic signed [15:0] top_row;
  logic signed [15:0] bottom_row;
  logic [FRAC_BITS-1:0] wall_fraction;
  logic [9:0] texel_column;
  logic saturated;
  modport source (output valid, wall_distance, line_height, top_row, bottom_row,
                  wall_fraction, texel_column, saturated, input ready);
  modport sink (input valid, wall_distance, line_height, top_row, bottom_row,
                wall_fraction, texel_column, saturated, output ready);
endinterface

interface rcws_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/rcws_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
module rcws_div #(
  parameter int NW = 32,
  parameter int DW = 24,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);
  logic          vld_r [NW+1];
  logic [NW-1:0] quo_r [NW+1];
  logic [DW:0]   rem_r [NW+1];
  logic [DW-1:0] den_r [NW+1];
  logic [PW-1:0] pay_r [NW+1];

  assign vld_r[0] = in_valid;
  assign quo_r[0] = in_num;
  assign rem_r[0] = '0;
  assign den_r[0] = in_den;
  assign pay_r[0] = in_pay;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW+1:0] trial;
    logic [DW:0]   shifted;
    assign shifted = {rem_r[s][DW-1:0], quo_r[s][NW-1]};
    assign trial = {1'b0, shifted} - {2'b00, den_r[s]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (en) begin
        if (!trial[DW+1]) begin
          rem_r[s+1] <= trial[DW:0];
        end else begin
          rem_r[s+1] <= shifted;
        end
        quo_r[s+1] <= {quo_r[s][NW-2:0], ~trial[DW+1]};
        den_r[s+1] <= den_r[s];
        pay_r[s+1] <= pay_r[s];
      end
    end
  end

  assign out_valid = vld_r[NW];
  assign out_quo   = quo_r[NW];
  assign out_pay   = pay_r[NW];
endmodule

@@ design/raycast_column_wall_setup.sv @@
// Pipeline: 2 + (MAP_BITS+2*FRAC_BITS+1) + 3 + (12+FRAC_BITS) + 2 register stages, 76 by default,
// most of them in two bit-per-stage dividers.
// Throughput: one column per cycle; the whole pipeline advances while the output register is free.
// A stall holds every stage, so nothing is lost or repeated.
// Synchronous active-low reset clears valid bits and returns the registers to 480 and 64.
// No memories, so there is no clearing pass after reset.
module raycast_column_wall_setup #(
  parameter int FRAC_BITS = rcws_pkg::FRAC_BITS_DEF,
  parameter int MAP_BITS  = rcws_pkg::MAP_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  rcws_in_if.sink   in_ch,
  rcws_out_if.source out_ch,
  rcws_cfg_if.sink  cfg_ch
);
  localparam int PW  = MAP_BITS + FRAC_BITS;
  localparam int DRW = FRAC_BITS + 3;
  localparam int NW  = PW + FRAC_BITS;       // magnitude of num then shifted
  localparam int QW  = NW;
  localparam int LW  = 12 + FRAC_BITS;       // screen_height << FRAC_BITS
  localparam logic [PW-1:0] DIST_MAX = {PW{1'b1}};
  localparam logic [FRAC_BITS-1:0] FMASK = {FRAC_BITS{1'b1}};

  logic [11:0] scr_h_r;
  logic [10:0] tex_w_r;
  logic en;
  logic out_vld_r;

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_h_r <= rcws_pkg::SCREEN_HEIGHT_RST;
      tex_w_r <= rcws_pkg::TEXTURE_WIDTH_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        rcws_pkg::REG_SCREEN_HEIGHT: scr_h_r <= cfg_ch.data;
        rcws_pkg::REG_TEXTURE_WIDTH: tex_w_r <= cfg_ch.data[10:0];
        default: ;
      endcase
    end
  end

  // Stage 1: numerator and axis selection.
  logic               s1_vld_r;
  logic signed [PW+1:0] s1_num_r;
  logic signed [DRW-1:0] s1_dir_r, s1_dro_r;
  logic [PW-1:0]      s1_eo_r;
  logic signed [PW+1:0] num_nxt;
  always_comb begin
    if (!in_ch.hit_side) begin
      num_nxt = $signed({2'b00, in_ch.cell_x, {FRAC_BITS{1'b0}}}) - $signed({2'b00, in_ch.eye_x})
                + $signed({{(PW+1){1'b0}}, in_ch.step_x_negative} << FRAC_BITS);
    end else begin
      num_nxt = $signed({2'b00, in_ch.cell_y, {FRAC_BITS{1'b0}}}) - $signed({2'b00, in_ch.eye_y})
                + $signed({{(PW+1){1'b0}}, in_ch.step_y_negative} << FRAC_BITS);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_ch.valid;
    if (en) begin
      s1_num_r <= num_nxt;
      s1_dir_r <= in_ch.hit_side ? in_ch.ray_y : in_ch.ray_x;
      s1_dro_r <= in_ch.hit_side ? in_ch.ray_x : in_ch.ray_y;
      s1_eo_r  <= in_ch.hit_side ? in_ch.eye_x : in_ch.eye_y;
    end
  end

  // Stage 2: magnitudes and signs.
  logic s2_vld_r, s2_zero_r, s2_neg_r;
  logic [PW:0] s2_nmag_r;
  logic [DRW-1:0] s2_dmag_r;
  logic signed [DRW-1:0] s2_dro_r;
  logic [PW-1:0] s2_eo_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
    if (en) begin
      s2_nmag_r <= s1_num_r[PW+1] ? (PW+1)'(0) - s1_num_r[PW:0] : s1_num_r[PW:0];
      s2_dmag_r <= s1_dir_r[DRW-1] ? DRW'(0) - s1_dir_r : s1_dir_r;
      s2_zero_r <= (s1_dir_r == '0);
      s2_neg_r  <= (s1_num_r < 0) != (s1_dir_r < 0);
      s2_dro_r  <= s1_dro_r;
      s2_eo_r   <= s1_eo_r;
    end
  end

  // Divider one: distance quotient.
  localparam int P1 = 2 + DRW + PW;
  logic d1_vld;
  logic [QW-1:0] d1_q;
  logic [QW:0] d1_q_w;
  logic [P1-1:0] d1_p;
  rcws_div #(.NW(QW+1), .DW(DRW), .PW(P1)) u_div_dist (
    .clk, .rst_n, .en, .in_valid(s2_vld_r),
    .in_num({s2_nmag_r, {FRAC_BITS{1'b0}}}),
    .in_den(s2_zero_r ? DRW'(1) : s2_dmag_r),
    .in_pay({s2_zero_r, s2_neg_r, s2_dro_r, s2_eo_r}),
    .out_valid(d1_vld), .out_quo(d1_q_w), .out_pay(d1_p)
  );
  assign d1_q = d1_q_w[QW-1:0];

  // Stage 3: classify distance.
  logic s3_vld_r, s3_sat_r, s3_near_r;
  logic [PW-1:0] s3_dist_r, s3_eo_r;
  logic signed [DRW-1:0] s3_dro_r;
  logic d1_zero, d1_neg;
  assign d1_zero = d1_p[P1-1];
  assign d1_neg  = d1_p[P1-2];
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (en) s3_vld_r <= d1_vld;
    if (en) begin
      s3_dro_r <= d1_p[PW +: DRW];
      s3_eo_r  <= d1_p[PW-1:0];
      if (d1_zero) begin
        s3_dist_r <= DIST_MAX; s3_sat_r <= 1'b1; s3_near_r <= 1'b0;
      end else if (d1_q_w == '0 || d1_neg) begin
        s3_dist_r <= '0; s3_sat_r <= 1'b1; s3_near_r <= 1'b1;
      end else if (d1_q_w > (QW+1)'(DIST_MAX)) begin
        s3_dist_r <= DIST_MAX; s3_sat_r <= 1'b1; s3_near_r <= 1'b0;
      end else begin
        s3_dist_r <= d1_q[PW-1:0]; s3_sat_r <= 1'b0; s3_near_r <= 1'b0;
      end
    end
  end

  // Stage 4: hit product (distance times other direction).
  logic s4_vld_r;
  logic [PW+DRW-1:0] s4_pm_r;
  logic s4_dneg_r;
  logic [PW-1:0] s4_eo_r;
  logic [PW-1:0] s4_dist_r;
  logic s4_sat_r, s4_near_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (en) s4_vld_r <= s3_vld_r;
    if (en) begin
      s4_pm_r  <= (PW+DRW)'(s3_dist_r) *
                  (PW+DRW)'(s3_dro_r[DRW-1] ? DRW'(0) - s3_dro_r : s3_dro_r);
      s4_dneg_r <= s3_dro_r[DRW-1];
      s4_eo_r <= s3_eo_r; s4_dist_r <= s3_dist_r;
      s4_sat_r <= s3_sat_r; s4_near_r <= s3_near_r;
    end
  end

  // Stage 5: fraction of hit.
  logic s5_vld_r, s5_sat_r, s5_near_r;
  logic [PW-1:0] s5_dist_r;
  logic [FRAC_BITS-1:0] s5_frac_r;
  logic [PW+DRW-1:0] pm_up;
  logic [FRAC_BITS-1:0] prod_f;
  assign pm_up = s4_pm_r + (PW+DRW)'(FMASK);
  assign prod_f = s4_dneg_r ? FRAC_BITS'(0) - pm_up[FRAC_BITS +: FRAC_BITS]
                            : s4_pm_r[FRAC_BITS +: FRAC_BITS];
  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else if (en) s5_vld_r <= s4_vld_r;
    if (en) begin
      s5_frac_r <= s4_eo_r[FRAC_BITS-1:0] + prod_f;
      s5_dist_r <= s4_dist_r; s5_sat_r <= s4_sat_r; s5_near_r <= s4_near_r;
    end
  end

  // Divider two: line height, with the rest of the result riding along.
  localparam int P2 = 2 + PW + FRAC_BITS;
  logic d2_vld;
  logic [LW-1:0] d2_q;
  logic [P2-1:0] d2_p;
  logic d2_pass_in;
  assign d2_pass_in = s5_near_r || (s5_dist_r == '0);
  rcws_div #(.NW(LW), .DW(PW), .PW(P2)) u_div_line (
    .clk, .rst_n, .en, .in_valid(s5_vld_r),
    .in_num({scr_h_r, {FRAC_BITS{1'b0}}}),
    .in_den(d2_pass_in ? PW'(1) : s5_dist_r),
    .in_pay({d2_pass_in, s5_sat_r, s5_dist_r, s5_frac_r}),
    .out_valid(d2_vld), .out_quo(d2_q), .out_pay(d2_p)
  );

  // Stage 6: line clamp and texel product.
  logic s6_vld_r, s6_sat_r;
  logic [14:0] s6_line_r;
  logic [PW-1:0] s6_dist_r;
  logic [FRAC_BITS-1:0] s6_frac_r;
  logic [FRAC_BITS+10:0] s6_tp_r;
  logic [FRAC_BITS-1:0] d2_frac;
  assign d2_frac = d2_p[FRAC_BITS-1:0];
  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else if (en) s6_vld_r <= d2_vld;
    if (en) begin
      if (d2_p[P2-1] || d2_q > LW'(rcws_pkg::LINE_MAX)) s6_line_r <= 15'(rcws_pkg::LINE_MAX);
      else s6_line_r <= d2_q[14:0];
      s6_sat_r  <= d2_p[P2-2];
      s6_dist_r <= d2_p[FRAC_BITS +: PW];
      s6_frac_r <= d2_frac;
      s6_tp_r   <= (FRAC_BITS+11)'(d2_frac) * (FRAC_BITS+11)'(tex_w_r);
    end
  end

  // Stage 7: rows and texel column into the output register.
  logic [16:0] bot_w;
  logic [10:0] tex_w;
  assign bot_w = 17'(s6_line_r[14:1]) + 17'(scr_h_r[11:1]);
  assign tex_w = s6_tp_r[FRAC_BITS +: 11];
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= s6_vld_r;
    if (en) begin
      out_ch.wall_distance <= s6_dist_r;
      out_ch.line_height   <= s6_line_r;
      out_ch.top_row       <= $signed(16'(scr_h_r[11:1])) - $signed(16'(s6_line_r[14:1]));
      out_ch.bottom_row    <= (bot_w > 17'd32767) ? 16'sd32767 : $signed(bot_w[15:0]);
      out_ch.wall_fraction <= s6_frac_r;
      out_ch.texel_column  <= (tex_w > 11'(rcws_pkg::TEXEL_MAX)) ? 10'(rcws_pkg::TEXEL_MAX)
                                                                 : tex_w[9:0];
      out_ch.saturated     <= s6_sat_r;
    end
  end
  assign out_ch.valid = out_vld_r;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_ch.wall_distance))
    else $error("result changed while stalled");
  a_near: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_ch.wall_distance == '0 |-> out_ch.saturated &&
    out_ch.line_height == 15'(rcws_pkg::LINE_MAX))
    else $error("zero distance without saturation");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.saturated |-> out_ch.wall_distance != '0)
    else $error("unflagged result with zero distance");
`endif
endmodule

@@ bench/tb_column_scoreboard.sv @@
// Scoreboard class holding predicted wall column results and checking received beats.
class column_scoreboard;
  typedef struct packed {
    logic [23:0] wdist;
    logic [14:0] line;
    logic [15:0] top;
    logic [15:0] bottom;
    logic [15:0] frac;
    logic [9:0]  texel;
    logic        sat;
  } column_t;

  column_t pending_columns[$];
  logic [11:0] screen_height = 12'd480;
  logic [10:0] texture_width = 11'd64;
  int errors = 0;
  int checked = 0;

  function void report(string what);
    $display("column check error: %s", what);
    errors++;
  endfunction

  function column_t project_column(logic [7:0] cx, logic [7:0] cy, logic [23:0] ex,
                                   logic [23:0] ey, logic signed [18:0] rx,
                                   logic signed [18:0] ry, logic side, logic sxn, logic syn);
    column_t c;
    longint num, dir, eo, dro, top, bottom, prod, hit;
    longint unsigned q, wdist, line, pm, frac, texel, amag, dmag;
    bit sat, near;
    sat = 0; near = 0;
    if (!side) begin
      num = (longint'(cx) << 16) - longint'(ex) + (sxn ? 65536 : 0);
      dir = rx; eo = ey; dro = ry;
    end else begin
      num = (longint'(cy) << 16) - longint'(ey) + (syn ? 65536 : 0);
      dir = ry; eo = ex; dro = rx;
    end
    if (dir == 0) begin
      wdist = 24'hFFFFFF; sat = 1;
    end else begin
      amag = num < 0 ? -num : num;
      dmag = dir < 0 ? -dir : dir;
      q = (amag << 16) / dmag;
      if (q == 0 || ((num < 0) != (dir < 0))) begin
        wdist = 0; sat = 1; near = 1;
      end else if (q > 64'hFFFFFF) begin
        wdist = 24'hFFFFFF; sat = 1;
      end else wdist = q;
    end
    if (near || wdist == 0) line = 32767;
    else begin
      line = (longint'(screen_height) << 16) / wdist;
      if (line > 32767) line = 32767;
    end
    top = longint'(screen_height / 2) - longint'(line / 2);
    bottom = longint'(line / 2) + longint'(screen_height / 2);
    if (bottom > 32767) bottom = 32767;
    pm = wdist * (dro < 0 ? -dro : dro);
    prod = dro < 0 ? -longint'((pm + 65535) >> 16) : longint'(pm >> 16);
    hit = eo + prod;
    frac = hit & 64'hFFFF;
    texel = (frac * texture_width) >> 16;
    if (texel > 1023) texel = 1023;
    c.wdist = 24'(wdist); c.line = 15'(line); c.top = 16'(top); c.bottom = 16'(bottom);
    c.frac = 16'(frac); c.texel = 10'(texel); c.sat = sat;
    return c;
  endfunction

  function void note_column(logic [7:0] cx, logic [7:0] cy, logic [23:0] ex, logic [23:0] ey,
                            logic signed [18:0] rx, logic signed [18:0] ry, logic side,
                            logic sxn, logic syn);
    pending_columns.push_back(project_column(cx, cy, ex, ey, rx, ry, side, sxn, syn));
  endfunction

  function void check_column(column_t got);
    column_t w;
    if (pending_columns.size() == 0) begin
      report("result beat with nothing pending");
      return;
    end
    w = pending_columns.pop_front();
    checked++;
    if (got.wdist !== w.wdist) report($sformatf("distance %h want %h", got.wdist, w.wdist));
    if (got.line !== w.line) report($sformatf("line height %0d want %0d", got.line, w.line));
    if (got.top !== w.top) report($sformatf("top row %h want %h", got.top, w.top));
    if (got.bottom !== w.bottom) report($sformatf("bottom row %h want %h", got.bottom, w.bottom));
    if (got.frac !== w.frac) report($sformatf("fraction %h want %h", got.frac, w.frac));
    if (got.texel !== w.texel) report($sformatf("texel %0d want %0d", got.texel, w.texel));
    if (got.sat !== w.sat) report($sformatf("saturated %b want %b", got.sat, w.sat));
  endfunction
endclass

@@ bench/tb.sv @@
// Top-level testbench for the raycaster wall column setup block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 2 + (8 + 32 + 1) + 3 + (12 + 16) + 2;

  logic clk = 0;
  logic rst_n = 0;
  always #1 clk = ~clk;

  rcws_in_if  in_ch();
  rcws_out_if out_ch();
  rcws_cfg_if cfg_ch();

  raycast_column_wall_setup dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                                 .cfg_ch(cfg_ch));

  column_scoreboard board = new();
  bit sink_quiet = 0;
  int sink_wait = 0;
  int sent = 0;

  initial begin
    in_ch.valid = 0; in_ch.cell_x = 0; in_ch.cell_y = 0; in_ch.eye_x = 0; in_ch.eye_y = 0;
    in_ch.ray_x = 0; in_ch.ray_y = 0; in_ch.hit_side = 0; in_ch.step_x_negative = 0;
    in_ch.step_y_negative = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = rcws_pkg::REG_SCREEN_HEIGHT; cfg_ch.data = 0;
  end

  // Receiver: after each beat it waits a drawn number of cycles, with runs of no waiting.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_column({out_ch.wall_distance, out_ch.line_height, out_ch.top_row,
                          out_ch.bottom_row, out_ch.wall_fraction, out_ch.texel_column,
                          out_ch.saturated});
      sink_wait = sink_quiet ? 0 : $urandom_range(0, 13);
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
    out_ch.ready <= (sink_wait == 0);
  end

  always @(posedge clk) if ($urandom_range(0, 199) == 0) sink_quiet <= ~sink_quiet;

  task automatic write_reg(logic [0:0] idx, logic [11:0] val);
    cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    if (idx == rcws_pkg::REG_SCREEN_HEIGHT) board.screen_height = val;
    else board.texture_width = val[10:0];
    @(posedge clk);
  endtask

  task automatic send_column(logic [7:0] cx, logic [7:0] cy, logic [23:0] ex, logic [23:0] ey,
                             logic [18:0] rx, logic [18:0] ry, logic side, logic sxn,
                             logic syn, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 13) : 0;
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.cell_x <= cx; in_ch.cell_y <= cy; in_ch.eye_x <= ex;
    in_ch.eye_y <= ey; in_ch.ray_x <= rx; in_ch.ray_y <= ry; in_ch.hit_side <= side;
    in_ch.step_x_negative <= sxn; in_ch.step_y_negative <= syn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_column(cx, cy, ex, ey, rx, ry, side, sxn, syn);
    sent++;
  endtask

  task automatic drain;
    in_ch.valid <= 0;
    while (board.pending_columns.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Mostly plausible hits: eye near the cell, modest ray components.
  task automatic send_random(bit gaps);
    logic [7:0] cx, cy;
    logic [23:0] ex, ey;
    logic [18:0] rx, ry;
    logic side;
    cx = 8'($urandom); cy = 8'($urandom); ex = 24'($urandom); ey = 24'($urandom);
    rx = 19'($urandom); ry = 19'($urandom); side = 1'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      ex = {cx - 8'($urandom_range(0, 6)) + 8'd3, 16'($urandom)};
      ey = {cy - 8'($urandom_range(0, 6)) + 8'd3, 16'($urandom)};
      rx = $signed(19'($urandom_range(0, 131072))) - 19'sd65536;
      ry = $signed(19'($urandom_range(0, 131072))) - 19'sd65536;
      if ($urandom_range(0, 15) == 0) rx = 0;
      if ($urandom_range(0, 15) == 0) ry = 0;
    end
    send_column(cx, cy, ex, ey, rx, ry, side, 1'($urandom), 1'($urandom), gaps);
  endtask

  initial begin : stimulus
    logic [11:0] heights[4] = '{12'd1, 12'd4095, 12'd480, 12'd200};
    logic [11:0] widths[4]  = '{12'd1, 12'd1024, 12'd64, 12'd0};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: far, near, saturation, extremes.
    send_column(8'd10, 8'd5, 24'h0A0000, 24'h050000, 19'sd0, 19'sd65536,
                1'b0, 1'b0, 1'b0, 1'b1);
    send_column(8'd10, 8'd5, 24'h0A0000, 24'h050000, 19'sd65536, 19'sd0,
                1'b1, 1'b0, 1'b0, 1'b1);
    send_column(8'd10, 8'd5, 24'h0A0000, 24'h058000, 19'sd65536, 19'sd3000,
                1'b0, 1'b0, 1'b0, 1'b1);
    send_column(8'd12, 8'd5, 24'h0A8000, 24'h058000, -19'sd65536, 19'sd1000,
                1'b0, 1'b0, 1'b0, 1'b1);
    send_column(8'd255, 8'd0, 24'h000000, 24'hFFFFFF, 19'sd1, -19'sd262144,
                1'b0, 1'b0, 1'b1, 1'b1);
    send_column(8'd0, 8'd255, 24'hFFFFFF, 24'h000000, 19'sd262143, -19'sd262144,
                1'b1, 1'b1, 1'b0, 1'b1);
    send_column(8'd11, 8'd5, 24'h0A0010, 24'h050000, 19'sd262143, -19'sd40000,
                1'b0, 1'b0, 1'b0, 1'b1);
    send_column(8'd3, 8'd3, 24'h030000, 24'h030000, -19'sd262144, 19'sd262143,
                1'b1, 1'b1, 1'b1, 1'b1);
    send_column(8'd200, 8'd50, 24'h0A0000, 24'h320000, 19'sd2, -19'sd2,
                1'b0, 1'b1, 1'b1, 1'b1);
    send_column(8'd9, 8'd9, 24'h08FFFF, 24'h090001, 19'sd65536, 19'sd65536,
                1'b1, 1'b0, 1'b1, 1'b1);
    drain();
    for (int phase = 0; phase < 5; phase++) begin
      if (phase < 4) begin
        write_reg(rcws_pkg::REG_SCREEN_HEIGHT, heights[phase]);
        write_reg(rcws_pkg::REG_TEXTURE_WIDTH, widths[phase]);
      end else begin
        write_reg(rcws_pkg::REG_SCREEN_HEIGHT, 12'($urandom_range(1, 4095)));
        write_reg(rcws_pkg::REG_TEXTURE_WIDTH, 12'($urandom_range(1, 1024)));
      end
      for (int n = 0; n < 230; n++) begin
        send_random(phase != 2);
        if (phase == 1 && n == 100) drain();
      end
      drain();
    end
    $display("Sent %0d columns over five register settings, %0d results checked.",
             sent, board.checked);
    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
